@@ hdl/smm_pkg.sv @@
// ----------------------------------------------------------------------------
// smm_pkg
// shared constants and types of the shift-or exact matcher
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 128;
    localparam int MASK_W      = 64;
    localparam int SYM_W       = $clog2(ALPHABET);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = $clog2(MAX_PATTERN);

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    localparam logic [MASK_W-1:0] MASK_ONES = '1;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
        logic [MASK_W-1:0] data;
    } t_wr_req;

endpackage

`default_nettype wire

@@ hdl/smm_ram.sv @@
// ----------------------------------------------------------------------------
// smm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/smm_mask_store.sv @@
// ----------------------------------------------------------------------------
// smm_mask_store
// character mask table: ram, per-entry valid bits and write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module smm_mask_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [smm_pkg::SYM_W-1:0]     i_rd_addr,
    input  wire smm_pkg::t_wr_req              i_wr,
    input  wire logic                          i_clear,
    output logic      [smm_pkg::MASK_W-1:0]    o_mask
);

    logic [smm_pkg::ALPHABET-1:0] r_valid;
    logic [smm_pkg::ALPHABET-1:0] n_valid;
    logic [smm_pkg::SYM_W-1:0]    r_rd_addr;
    smm_pkg::t_wr_req             r_fwd;
    logic [smm_pkg::MASK_W-1:0]   rdata;

    smm_ram #(
        .WIDTH(smm_pkg::MASK_W),
        .DEPTH(smm_pkg::ALPHABET)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_wr.en),
        .i_waddr(i_wr.addr),
        .i_wdata(i_wr.data),
        .i_re   (i_rd_en),
        .i_raddr(i_rd_addr),
        .o_rdata(rdata)
    );

    // entries never written since the last clear read as all ones
    always_comb begin
        n_valid = i_clear ? '0 : r_valid;
        if (i_wr.en) begin
            n_valid[i_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fwd.en <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_rd_en) begin
                r_fwd.en <= i_wr.en;
            end
        end
        if (i_rd_en) begin
            r_rd_addr  <= i_rd_addr;
            r_fwd.addr <= i_wr.addr;
            r_fwd.data <= i_wr.data;
        end
    end

    // write landing in the same cycle as the read is taken from the bypass
    always_comb begin
        if (r_fwd.en && (r_fwd.addr == r_rd_addr)) begin
            o_mask = r_fwd.data;
        end else if (r_valid[r_rd_addr]) begin
            o_mask = rdata;
        end else begin
            o_mask = smm_pkg::MASK_ONES;
        end
    end

endmodule

`default_nettype wire

@@ hdl/shift_or_exact_matcher.sv @@
// ----------------------------------------------------------------------------
// shift_or_exact_matcher
// shift-or exact matcher with streamed pattern load and text scan
// ----------------------------------------------------------------------------
// a text request's result is registered after the mask table read
// throughput: one request per cycle, pattern or text, back to back unless stalled
// mask table read, then result register; a same-entry write is bypassed
// input stalls only while the result register holds an untaken result
// reset: synchronous; masks read as all ones through per-entry valid bits,
// no clearing pass, the block takes requests in the first cycle after reset
`default_nettype none

module shift_or_exact_matcher (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_command,
    input  wire logic [smm_pkg::SYM_W-1:0] i_symbol,
    input  wire logic                      i_restart,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_match_here,
    output logic                           o_found_in_text,
    output logic                           o_pattern_overflow
);

    logic                          r_s1_valid;
    logic                          r_s1_cmd;
    logic                          r_s1_restart;
    logic [smm_pkg::SYM_W-1:0]     r_s1_sym;
    logic [smm_pkg::LEN_W-1:0]     r_len;
    logic                          r_ovf;
    logic [smm_pkg::MASK_W-1:0]    r_sv;
    logic                          r_found;
    logic                          r_o_valid;
    logic                          r_o_match;
    logic                          r_o_found;
    logic                          r_o_ovf;

    logic                          accept;
    logic                          s1_fire;
    logic                          is_pat;
    logic                          is_txt;
    logic [smm_pkg::MASK_W-1:0]    store_mask;
    logic [smm_pkg::MASK_W-1:0]    mask_eff;
    logic [smm_pkg::LEN_W-1:0]     base_len;
    logic                          pat_full;
    smm_pkg::t_wr_req              wr;
    logic                          clear;
    logic [smm_pkg::MASK_W-1:0]    n_sv;
    logic [smm_pkg::LEN_W-1:0]     len_m1;
    logic                          hit;
    logic                          n_found;

    assign s1_fire = r_s1_valid
                   && ((r_s1_cmd == smm_pkg::CMD_PATTERN) || !r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    assign is_pat = s1_fire && (r_s1_cmd == smm_pkg::CMD_PATTERN);
    assign is_txt = s1_fire && (r_s1_cmd == smm_pkg::CMD_TEXT);
    assign clear  = is_pat && r_s1_restart;

    smm_mask_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_addr(i_symbol),
        .i_wr     (wr),
        .i_clear  (clear),
        .o_mask   (store_mask)
    );

    // pattern load
    always_comb begin
        mask_eff = clear ? smm_pkg::MASK_ONES : store_mask;
        base_len = r_s1_restart ? '0 : r_len;
        pat_full = (base_len >= smm_pkg::LEN_W'(smm_pkg::MAX_PATTERN));
        wr.en    = is_pat && !pat_full;
        wr.addr  = r_s1_sym;
        wr.data  = mask_eff
                 & ~(smm_pkg::MASK_W'(1) << base_len[smm_pkg::POS_W-1:0]);
    end

    // text scan
    always_comb begin
        n_sv    = ((r_s1_restart ? smm_pkg::MASK_ONES : r_sv) << 1) | store_mask;
        len_m1  = r_len - smm_pkg::LEN_W'(1);
        hit     = (r_len != '0) && !r_ovf && !n_sv[len_m1[smm_pkg::POS_W-1:0]];
        n_found = (r_s1_restart ? 1'b0 : r_found) | hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_sv       <= smm_pkg::MASK_ONES;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (is_pat) begin
                if (r_s1_restart) begin
                    r_sv    <= smm_pkg::MASK_ONES;
                    r_found <= 1'b0;
                end
                if (pat_full) begin
                    r_ovf <= 1'b1;
                    r_len <= base_len;
                end else begin
                    r_ovf <= r_s1_restart ? 1'b0 : r_ovf;
                    r_len <= base_len + smm_pkg::LEN_W'(1);
                end
            end
            if (is_txt) begin
                r_sv    <= n_sv;
                r_found <= n_found;
            end
            if (is_txt) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_s1_cmd     <= i_command;
            r_s1_restart <= i_restart;
            r_s1_sym     <= i_symbol;
        end
        if (is_txt) begin
            r_o_match <= hit;
            r_o_found <= n_found;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_match_here       = r_o_match;
    assign o_found_in_text    = r_o_found;
    assign o_pattern_overflow = r_o_ovf;

endmodule

`default_nettype wire

@@ hdl/smm_checker.sv @@
// ----------------------------------------------------------------------------
// smm_checker
// port-level checks of the shift-or exact matcher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module smm_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_ready,
    input wire logic                      i_command,
    input wire logic [smm_pkg::SYM_W-1:0] i_symbol,
    input wire logic                      i_restart,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic                      o_match_here,
    input wire logic                      o_found_in_text,
    input wire logic                      o_pattern_overflow
);

    // a match always shows in the sticky flag
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_here |-> o_found_in_text)
        else $error("match without found flag");

    // a refused pattern never matches
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pattern_overflow |-> !o_match_here)
        else $error("match reported on overflowed pattern");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_here)
            && $stable(o_found_in_text) && $stable(o_pattern_overflow))
        else $error("stalled result changed");

endmodule

bind shift_or_exact_matcher smm_checker u_smm_checker (.*);

`default_nettype wire
